// ===== rtl/core/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg: shared types and constants of the Intel HEX record writer
// Item kinds, error codes, character slot codes, the per-item emission
// plan and the hex digit helper.
// ----------------------------------------------------------------------------
package ihex_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_SKIP = 2'd2,
    KIND_BAD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ADDR = 2'd1,
    ERR_KIND = 2'd2
  } err_t;

  // Record type bytes as they appear on the line.
  localparam logic [7:0] RTYPE_DATA = 8'h00;
  localparam logic [7:0] RTYPE_END  = 8'h01;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_A       = 8'h41;

  // Character positions of one line, in emission order.
  typedef enum logic [3:0] {
    SLOT_COLON   = 4'd0,
    SLOT_CNT_HI  = 4'd1,
    SLOT_CNT_LO  = 4'd2,
    SLOT_AH_HI   = 4'd3,
    SLOT_AH_LO   = 4'd4,
    SLOT_AL_HI   = 4'd5,
    SLOT_AL_LO   = 4'd6,
    SLOT_TYPE_HI = 4'd7,
    SLOT_TYPE_LO = 4'd8,
    SLOT_DATA_HI = 4'd9,
    SLOT_DATA_LO = 4'd10,
    SLOT_CK_HI   = 4'd11,
    SLOT_CK_LO   = 4'd12,
    SLOT_NL      = 4'd13,
    SLOT_ERR     = 4'd14
  } slot_t;

  // Everything needed to produce the characters of one input item.
  typedef struct packed {
    err_t        err;
    logic        has_head;
    logic        has_data;
    logic        has_tail;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [7:0]  data;
    logic [7:0]  cksum;
  } plan_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHAR_ZERO + {4'd0, v};
    end else begin
      r = CHAR_A + {4'd0, v - 4'd10};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ihex_planner.sv =====
// ----------------------------------------------------------------------------
// ihex_planner: record state and per-item emission plan
// Decodes one input beat against the open-record state, produces the plan
// of characters it causes and updates the state when the beat is taken.
// ----------------------------------------------------------------------------
module ihex_planner import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  input  logic [7:0]  length,
  input  logic [7:0]  data_byte,
  output plan_t       plan,
  output logic        plan_valid
);

  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       in_record, in_record_next;

  logic       addr_ok;
  logic [7:0] head_sum;
  logic [7:0] rec_sum;
  logic [7:0] left_dec;

  always_comb begin
    addr_ok  = (address[31:16] == 16'd0);
    plan     = '0;
    plan.err = ERR_NONE;
    plan_valid = 1'b0;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    in_record_next   = in_record;
    head_sum = 8'd0;
    rec_sum  = 8'd0;
    left_dec = bytes_left - 8'd1;

    if (in_record) begin
      // Continuation byte of an open data record.
      rec_sum          = running_sum + data_byte;
      plan_valid       = 1'b1;
      plan.has_data    = 1'b1;
      plan.data        = data_byte;
      running_sum_next = rec_sum;
      bytes_left_next  = left_dec;
      if (left_dec == 8'd0) begin
        plan.has_tail  = 1'b1;
        plan.cksum     = 8'd0 - rec_sum;
        in_record_next = 1'b0;
      end
    end else begin
      case (kind_t'(kind))
        KIND_DATA: begin
          plan_valid = 1'b1;
          if (!addr_ok) begin
            plan.err = ERR_ADDR;
          end else begin
            plan.has_head = 1'b1;
            plan.count    = length;
            plan.addr     = address[15:0];
            plan.rtype    = RTYPE_DATA;
            head_sum      = length + address[15:8] + address[7:0] + RTYPE_DATA;
            rec_sum       = head_sum + data_byte;
            if (length == 8'd0) begin
              plan.has_tail = 1'b1;
              plan.cksum    = 8'd0 - head_sum;
            end else begin
              plan.has_data = 1'b1;
              plan.data     = data_byte;
              if (length == 8'd1) begin
                plan.has_tail = 1'b1;
                plan.cksum    = 8'd0 - rec_sum;
              end else begin
                in_record_next   = 1'b1;
                running_sum_next = rec_sum;
                bytes_left_next  = length - 8'd1;
              end
            end
          end
        end
        KIND_END: begin
          plan_valid = 1'b1;
          if (!addr_ok) begin
            plan.err = ERR_ADDR;
          end else begin
            plan.has_head = 1'b1;
            plan.has_tail = 1'b1;
            plan.addr     = address[15:0];
            plan.rtype    = RTYPE_END;
            head_sum      = address[15:8] + address[7:0] + RTYPE_END;
            plan.cksum    = 8'd0 - head_sum;
          end
        end
        KIND_SKIP: begin
          plan_valid = 1'b0;
        end
        default: begin
          plan_valid = 1'b1;
          plan.err   = ERR_KIND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
      in_record   <= 1'b0;
    end else if (take) begin
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      in_record   <= in_record_next;
    end
  end

endmodule

// ===== rtl/core/intel_hex_record_writer_unit.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_writer_unit: Intel HEX text writer
// Turns record beats into the ASCII characters of Intel HEX lines.
// ----------------------------------------------------------------------------
// Each accepted input beat is decoded at once against the open-record state
// into a compact plan, held in a one-deep plan register, and then spelled
// out by a character sequencer into the output register at one character
// per cycle while the output register is free or being taken. A beat causes
// two characters for a byte in the middle of a record, five for the closing
// byte, up to fourteen for a one-byte record, twelve for a termination line,
// one for an error beat and none for a skip beat. The output port is the
// limit; the next beat is taken while the current plan is still being
// spelled out, so the output stays busy on every cycle that it is ready.
// The address must be below 65536; otherwise the beat yields one error beat
// with a zero character. There is no start-up pass after reset.
module intel_hex_record_writer_unit import ihex_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // address[31:0], length[39:32], data_byte[47:40]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // text_char[7:0]
  output logic [1:0]  m_tuser,   // error[1:0]
  output logic        m_tlast
);

  // Plan of the next beat, waiting for the sequencer.
  plan_t pend;
  logic  pend_valid;

  // Plan being spelled out and the position within it.
  plan_t act;
  logic  act_valid;
  slot_t slot;

  plan_t new_plan;
  logic  new_plan_valid;
  logic  s_accept;
  logic  emit;
  logic  act_last;
  logic  pend_take;
  slot_t slot_next;
  slot_t start_slot;
  logic [7:0] char_cur;

  ihex_planner u_planner (
    .clk       (clk),
    .rst       (rst),
    .take      (s_accept),
    .kind      (s_tuser),
    .address   (s_tdata[31:0]),
    .length    (s_tdata[39:32]),
    .data_byte (s_tdata[47:40]),
    .plan      (new_plan),
    .plan_valid(new_plan_valid)
  );

  // A character moves into the output register whenever it is free or being
  // taken this cycle.
  assign emit      = act_valid && (!m_tvalid || m_tready);
  assign act_last  = (slot == SLOT_NL) || (slot == SLOT_ERR) ||
                     ((slot == SLOT_DATA_LO) && !act.has_tail);
  assign pend_take = pend_valid && (!act_valid || (emit && act_last));
  assign s_tready  = !pend_valid || pend_take;
  assign s_accept  = s_tvalid && s_tready;

  // Lines start at the colon; a continuation byte starts at its data digits.
  always_comb begin
    if (pend.has_head) begin
      start_slot = SLOT_COLON;
    end else if (pend.has_data) begin
      start_slot = SLOT_DATA_HI;
    end else begin
      start_slot = SLOT_ERR;
    end
  end

  always_comb begin
    case (slot)
      SLOT_TYPE_LO: slot_next = act.has_data ? SLOT_DATA_HI : SLOT_CK_HI;
      SLOT_DATA_LO: slot_next = SLOT_CK_HI;
      SLOT_NL:      slot_next = SLOT_NL;
      SLOT_ERR:     slot_next = SLOT_ERR;
      default:      slot_next = slot_t'(slot + 4'd1);
    endcase
  end

  always_comb begin
    case (slot)
      SLOT_COLON:   char_cur = CHAR_COLON;
      SLOT_CNT_HI:  char_cur = hex_digit(act.count[7:4]);
      SLOT_CNT_LO:  char_cur = hex_digit(act.count[3:0]);
      SLOT_AH_HI:   char_cur = hex_digit(act.addr[15:12]);
      SLOT_AH_LO:   char_cur = hex_digit(act.addr[11:8]);
      SLOT_AL_HI:   char_cur = hex_digit(act.addr[7:4]);
      SLOT_AL_LO:   char_cur = hex_digit(act.addr[3:0]);
      SLOT_TYPE_HI: char_cur = hex_digit(act.rtype[7:4]);
      SLOT_TYPE_LO: char_cur = hex_digit(act.rtype[3:0]);
      SLOT_DATA_HI: char_cur = hex_digit(act.data[7:4]);
      SLOT_DATA_LO: char_cur = hex_digit(act.data[3:0]);
      SLOT_CK_HI:   char_cur = hex_digit(act.cksum[7:4]);
      SLOT_CK_LO:   char_cur = hex_digit(act.cksum[3:0]);
      SLOT_NL:      char_cur = CHAR_NEWLINE;
      default:      char_cur = 8'h00;
    endcase
  end

  // Plan register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_accept && new_plan_valid) begin
      pend_valid <= 1'b1;
    end else if (pend_take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && new_plan_valid) begin
      pend <= new_plan;
    end
  end

  // Character sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
      slot      <= SLOT_COLON;
    end else if (pend_take) begin
      act_valid <= 1'b1;
      slot      <= start_slot;
    end else if (emit && act_last) begin
      act_valid <= 1'b0;
    end else if (emit) begin
      slot <= slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      act <= pend;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char_cur;
      m_tlast <= act_last;
      m_tuser <= (slot == SLOT_ERR) ? act.err : ERR_NONE;
    end
  end

  // An error beat always closes its item and carries no character.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ERR_NONE) |-> m_tlast && (m_tdata == 8'h00))
    else $error("error beat without last or with a character");

  // A waiting plan is picked up by an idle sequencer in the next cycle.
  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !act_valid |=> act_valid)
    else $error("plan register stalled while sequencer idle");

  // The error position is only reached by plans that carry an error code.
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    act_valid && (slot == SLOT_ERR) |-> (act.err != ERR_NONE))
    else $error("error slot reached by a plan without an error");

  // A plan with an error code never spells any line characters.
  a_err_plan: assert property (@(posedge clk) disable iff (rst)
    act_valid && (act.err != ERR_NONE) |-> (slot == SLOT_ERR))
    else $error("plan with error code spelling characters");

endmodule
